>>> rtl/shad_pkg.sv
// Package for the slow HTTP attack detector: word types, flow-table types,
// register map, rule codes and shared constants. No dependencies.
`timescale 1ns / 1ps

package shad_pkg;

    // Flow table size, a power of two from 1 to 65536.
    localparam int FLOW_SLOTS = 256;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [7:0]  TCP_PROTOCOL = 8'd6;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_LF      = 8'h0A;
    localparam logic [2:0]  TERM_MATCH   = 3'd4;
    localparam logic [19:0] US_PER_SEC   = 20'd1000000;

    localparam logic [15:0] RST_WEB_PORT    = 16'd80;
    localparam logic [15:0] RST_SECURE_PORT = 16'd443;
    localparam logic [31:0] RST_TIMEOUT_US  = 32'd30000000;
    localparam logic [19:0] RST_MIN_RATE    = 20'd100;
    localparam logic [15:0] RST_ZW_MIN_PKTS = 16'd5;

    typedef enum logic {
        OP_HEADER  = 1'b0,
        OP_PAYLOAD = 1'b1
    } t_op_code;

    typedef enum logic [1:0] {
        RULE_NONE           = 2'd0,
        RULE_HEADER_TIMEOUT = 2'd1,
        RULE_LOW_RATE       = 2'd2,
        RULE_ZERO_WINDOW    = 2'd3
    } t_rule;

    typedef enum logic [2:0] {
        REG_WEB_PORT    = 3'd0,
        REG_SECURE_PORT = 3'd1,
        REG_TIMEOUT_US  = 3'd2,
        REG_MIN_RATE    = 3'd3,
        REG_ZW_MIN_PKTS = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic        operation;
        logic [7:0]  flow_index;
        logic [7:0]  ip_protocol;
        logic [15:0] destination_port;
        logic        syn_flag;
        logic        ack_flag;
        logic [15:0] payload_length;
        logic [15:0] window_size;
        logic [31:0] flow_packet_count;
        logic [47:0] time_us;
        logic [7:0]  payload_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] flow_slot;
        logic       attack_detected;
        logic [1:0] rule_hit;
    } t_out_word;

    typedef struct packed {
        logic [15:0] web_port;
        logic [15:0] secure_web_port;
        logic [31:0] header_timeout_us;
        logic [19:0] min_rate_bytes_per_sec;
        logic [15:0] zero_window_min_packets;
    } t_cfg;

    // One flow-table operation handed from the front end to the back end.
    typedef struct packed {
        logic [7:0]  flow_index;
        logic        wr;          // header of an analysed packet
        logic        restart;     // SYN without ACK
        logic [15:0] add_len;
        logic        set_done;    // terminator seen
        logic        emit;        // last item of the packet
        logic        analysed;    // verdict rules apply
        logic [47:0] time_us;
        logic        window_zero;
        logic [31:0] packet_count;
    } t_flow_op;

    typedef struct packed {
        logic [47:0] start_time;
        logic [31:0] byte_total;
    } t_flow_entry;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] idx);
        logic [16:0] wide;
        wide = {9'b0, idx} & 17'(FLOW_SLOTS - 1);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> rtl/shad_regs.sv
// Configuration registers behind the APB-style port.
// Depends on shad_pkg.
`timescale 1ns / 1ps

module shad_regs import shad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.web_port                <= RST_WEB_PORT;
            r_cfg.secure_web_port         <= RST_SECURE_PORT;
            r_cfg.header_timeout_us       <= RST_TIMEOUT_US;
            r_cfg.min_rate_bytes_per_sec  <= RST_MIN_RATE;
            r_cfg.zero_window_min_packets <= RST_ZW_MIN_PKTS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WEB_PORT:    r_cfg.web_port                <= pwdata[15:0];
                REG_SECURE_PORT: r_cfg.secure_web_port         <= pwdata[15:0];
                REG_TIMEOUT_US:  r_cfg.header_timeout_us       <= pwdata[31:0];
                REG_MIN_RATE:    r_cfg.min_rate_bytes_per_sec  <= pwdata[19:0];
                REG_ZW_MIN_PKTS: r_cfg.zero_window_min_packets <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WEB_PORT:    prdata = {16'b0, r_cfg.web_port};
            REG_SECURE_PORT: prdata = {16'b0, r_cfg.secure_web_port};
            REG_TIMEOUT_US:  prdata = r_cfg.header_timeout_us;
            REG_MIN_RATE:    prdata = {12'b0, r_cfg.min_rate_bytes_per_sec};
            REG_ZW_MIN_PKTS: prdata = {16'b0, r_cfg.zero_window_min_packets};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/shad_front.sv
// Front end: classifies header words, tracks the open packet and scans
// payload bytes for CR LF CR LF. Emits flow-table operations. Depends on shad_pkg.
`timescale 1ns / 1ps

module shad_front import shad_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_word i_data,
    output logic     o_push,
    output t_flow_op o_op
);

    logic [7:0]  r_slot,      n_slot;
    logic        r_analysed,  n_analysed;
    logic [15:0] r_remaining, n_remaining;
    logic [2:0]  r_progress,  n_progress;
    logic        r_wz,        n_wz;
    logic [31:0] r_count,     n_count;
    logic [47:0] r_time,      n_time;

    logic analysed;
    logic restart;
    logic want_cr;
    logic matched;

    always_comb begin
        n_slot      = r_slot;
        n_analysed  = r_analysed;
        n_remaining = r_remaining;
        n_progress  = r_progress;
        n_wz        = r_wz;
        n_count     = r_count;
        n_time      = r_time;
        o_push      = 1'b0;
        o_op        = '0;
        analysed    = (i_data.ip_protocol == TCP_PROTOCOL) &&
                      ((i_data.destination_port == i_cfg.web_port) ||
                       (i_data.destination_port == i_cfg.secure_web_port));
        restart     = i_data.syn_flag && !i_data.ack_flag;
        want_cr     = (r_progress == 3'd0) || (r_progress == 3'd2);
        matched     = want_cr ? (i_data.payload_byte == CHAR_CR)
                              : (i_data.payload_byte == CHAR_LF);

        if (i_accept) begin
            if (i_data.operation == OP_HEADER) begin
                n_slot      = i_data.flow_index;
                n_analysed  = analysed && !restart;
                n_remaining = i_data.payload_length;
                n_progress  = 3'd0;
                n_wz        = (i_data.window_size == 16'd0);
                n_count     = i_data.flow_packet_count;
                n_time      = i_data.time_us;

                o_op.flow_index   = i_data.flow_index;
                o_op.wr           = analysed;
                o_op.restart      = restart;
                o_op.add_len      = i_data.payload_length;
                o_op.emit         = (i_data.payload_length == 16'd0);
                o_op.analysed     = n_analysed;
                o_op.time_us      = i_data.time_us;
                o_op.window_zero  = n_wz;
                o_op.packet_count = i_data.flow_packet_count;
                o_push            = analysed || o_op.emit;
            end else if (r_remaining != 16'd0) begin
                n_remaining = r_remaining - 16'd1;
                if (r_analysed && (r_progress < TERM_MATCH)) begin
                    if (matched) begin
                        n_progress = r_progress + 3'd1;
                    end else begin
                        n_progress = (i_data.payload_byte == CHAR_CR) ? 3'd1 : 3'd0;
                    end
                end

                o_op.flow_index   = r_slot;
                o_op.set_done     = r_analysed && (r_progress < TERM_MATCH) &&
                                    (n_progress == TERM_MATCH);
                o_op.emit         = (r_remaining == 16'd1);
                o_op.analysed     = r_analysed;
                o_op.time_us      = r_time;
                o_op.window_zero  = r_wz;
                o_op.packet_count = r_count;
                o_push            = o_op.set_done || o_op.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_analysed  <= 1'b0;
            r_remaining <= '0;
            r_progress  <= '0;
            r_wz        <= 1'b0;
            r_count     <= '0;
            r_time      <= '0;
        end else begin
            r_slot      <= n_slot;
            r_analysed  <= n_analysed;
            r_remaining <= n_remaining;
            r_progress  <= n_progress;
            r_wz        <= n_wz;
            r_count     <= n_count;
            r_time      <= n_time;
        end
    end

endmodule

>>> rtl/shad_queue.sv
// Short FIFO of flow-table operations between front and back end.
// Depends on shad_pkg.
`timescale 1ns / 1ps

module shad_queue import shad_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_flow_op i_op,
    input  logic     i_pop,
    output t_flow_op o_op,
    output logic     o_empty,
    output logic     o_full
);

    t_flow_op           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/shad_back.sv
// Back end: flow table (start time, byte total, header-done) and the
// four-stage verdict pipeline with output register. Depends on shad_pkg.
`timescale 1ns / 1ps

module shad_back import shad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_flow_op  i_op,
    input  logic      i_op_valid,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_word o_data,
    input  logic      i_stall
);

    t_flow_entry       r_mem [FLOW_SLOTS];
    logic [FLOW_SLOTS-1:0] r_vld;
    logic [FLOW_SLOTS-1:0] r_done;

    logic              r_fw_valid;
    logic [SLOT_W-1:0] r_fw_slot;
    t_flow_entry       r_fw_entry;

    // stage 1: table read data and read-modify-write
    logic              r_b1_valid;
    t_flow_op          r_b1_op;
    t_flow_entry       r_rd_entry;

    // stage 2: multiplies
    logic              r_b2_valid;
    logic [7:0]        r_b2_slot;
    logic              r_b2_analysed;
    logic              r_b2_done;
    logic [47:0]       r_b2_elapsed;
    logic [31:0]       r_b2_bytes;
    logic              r_b2_wz;
    logic [31:0]       r_b2_count;

    // stage 3: rate compare and rule select
    logic              r_b3_valid;
    logic [7:0]        r_b3_slot;
    logic              r_b3_analysed;
    logic              r_b3_done;
    logic              r_b3_timed_out;
    logic [43:0]       r_b3_hi;
    logic [43:0]       r_b3_lo;
    logic [51:0]       r_b3_lhs;
    logic              r_b3_zw;

    logic              r_out_valid;
    t_out_word         r_out_data;

    logic              en;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] b1_slot;
    logic              fwd_hit;
    t_flow_entry       cur;
    t_flow_entry       new_entry;
    t_flow_entry       eff;
    logic [32:0]       byte_sum;
    logic              wr_now;
    logic              done_now;
    logic [47:0]       elapsed;

    logic              timed_out;
    logic [43:0]       hi_prod;
    logic [43:0]       lo_prod;
    logic [51:0]       lhs_prod;
    logic              zw_hit;

    logic [54:0]       rhs_sum;
    logic              rate_low;
    t_rule             rule;

    assign en        = !(r_out_valid && i_stall);
    assign o_pop     = en && i_op_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;
    assign head_slot = slot_of(i_op.flow_index);
    assign b1_slot   = slot_of(r_b1_op.flow_index);

    always_comb begin
        fwd_hit  = r_fw_valid && (r_fw_slot == b1_slot);
        if (fwd_hit) begin
            cur = r_fw_entry;
        end else if (r_vld[b1_slot]) begin
            cur = r_rd_entry;
        end else begin
            cur = '0;
        end
        byte_sum = {1'b0, cur.byte_total} + {17'b0, r_b1_op.add_len};
        if (r_b1_op.restart) begin
            new_entry.start_time = r_b1_op.time_us;
            new_entry.byte_total = '0;
        end else begin
            new_entry.start_time = cur.start_time;
            new_entry.byte_total = byte_sum[32] ? '1 : byte_sum[31:0];
        end
        eff      = r_b1_op.wr ? new_entry : cur;
        wr_now   = en && r_b1_valid && r_b1_op.wr;
        done_now = r_b1_op.set_done ||
                   (!(r_b1_op.wr && r_b1_op.restart) && r_done[b1_slot]);
        elapsed  = (r_b1_op.time_us >= eff.start_time) ?
                   (r_b1_op.time_us - eff.start_time) : '0;
    end

    always_comb begin
        timed_out = r_b2_elapsed > {16'b0, i_cfg.header_timeout_us};
        hi_prod   = {20'b0, r_b2_elapsed[47:24]} * {24'b0, i_cfg.min_rate_bytes_per_sec};
        lo_prod   = {20'b0, r_b2_elapsed[23:0]} * {24'b0, i_cfg.min_rate_bytes_per_sec};
        lhs_prod  = {20'b0, r_b2_bytes} * {32'b0, US_PER_SEC};
        zw_hit    = r_b2_wz && (r_b2_count > {16'b0, i_cfg.zero_window_min_packets});
    end

    always_comb begin
        rhs_sum  = {1'b0, r_b3_hi[29:0], 24'b0} + {11'b0, r_b3_lo};
        rate_low = (|r_b3_hi[43:30]) || (rhs_sum > {3'b0, r_b3_lhs});
        if (!r_b3_analysed) begin
            rule = RULE_NONE;
        end else if (!r_b3_done && r_b3_timed_out) begin
            rule = RULE_HEADER_TIMEOUT;
        end else if (r_b3_timed_out && rate_low) begin
            rule = RULE_LOW_RATE;
        end else if (r_b3_zw) begin
            rule = RULE_ZERO_WINDOW;
        end else begin
            rule = RULE_NONE;
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_now) begin
            r_mem[b1_slot] <= new_entry;
        end
        if (en) begin
            r_rd_entry <= r_mem[head_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_done      <= '0;
            r_fw_valid  <= 1'b0;
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_now) begin
                r_vld[b1_slot] <= 1'b1;
                r_fw_valid     <= 1'b1;
                if (r_b1_op.restart) begin
                    r_done[b1_slot] <= 1'b0;
                end
            end
            if (en && r_b1_valid && r_b1_op.set_done) begin
                r_done[b1_slot] <= 1'b1;
            end
            if (en) begin
                r_b1_valid  <= i_op_valid;
                r_b2_valid  <= r_b1_valid && r_b1_op.emit;
                r_b3_valid  <= r_b2_valid;
                r_out_valid <= r_b3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_now) begin
            r_fw_slot  <= b1_slot;
            r_fw_entry <= new_entry;
        end
        if (en) begin
            r_b1_op        <= i_op;

            r_b2_slot      <= r_b1_op.flow_index;
            r_b2_analysed  <= r_b1_op.analysed;
            r_b2_done      <= done_now;
            r_b2_elapsed   <= elapsed;
            r_b2_bytes     <= eff.byte_total;
            r_b2_wz        <= r_b1_op.window_zero;
            r_b2_count     <= r_b1_op.packet_count;

            r_b3_slot      <= r_b2_slot;
            r_b3_analysed  <= r_b2_analysed;
            r_b3_done      <= r_b2_done;
            r_b3_timed_out <= timed_out;
            r_b3_hi        <= hi_prod;
            r_b3_lo        <= lo_prod;
            r_b3_lhs       <= lhs_prod;
            r_b3_zw        <= zw_hit;

            r_out_data.flow_slot       <= r_b3_slot;
            r_out_data.attack_detected <= (rule != RULE_NONE);
            r_out_data.rule_hit        <= rule;
        end
    end

endmodule

>>> rtl/slow_http_attack_detector.sv
// Slow HTTP attack detector, top level. Uses shad_pkg, shad_regs, shad_front,
// shad_queue and shad_back.
// A verdict is registered through the operation queue and the back-end stages.
// One word per cycle while o_stall is low; the 4-entry queue absorbs output stalls.
// Reset: synchronous, active low; clears flow table valid and header-done bits,
// queue, pipeline and packet state, and loads the register defaults.
`timescale 1ns / 1ps

module slow_http_attack_detector import shad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_word           i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_word          o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg     cfg;
    logic     accept;
    logic     push;
    t_flow_op push_op;
    t_flow_op head_op;
    logic     q_empty;
    logic     q_full;
    logic     pop;

    assign o_stall = q_full;
    assign accept  = i_valid && !o_stall;

    shad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    shad_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (push),
        .o_op     (push_op)
    );

    shad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    shad_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_op       (head_op),
        .i_op_valid (!q_empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

endmodule

>>> rtl/shad_checker.sv
// Port-level assertions for slow_http_attack_detector, bound to the top level.
// Depends on shad_pkg.
`timescale 1ns / 1ps

module shad_checker import shad_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");

    a_flag_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.attack_detected == (o_data.rule_hit != RULE_NONE)))
        else $error("attack flag disagrees with rule");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without output back-pressure");

endmodule

bind slow_http_attack_detector shad_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
